@@ sv/pcbs_pkg.sv @@
// Shared types and constants for the per-class box suppression block.
`default_nettype none
package pcbs_pkg;

    localparam int COORD_W   = 16;
    localparam int LEN_W     = 15;
    localparam int CLASS_W   = 7;
    localparam int EDGE_W    = 17;
    localparam int AREA_W    = 30;
    localparam int UNION_W   = 31;
    localparam int THR_W     = 16;
    localparam int PROD_W    = 47;
    localparam int BOX_NUM_W = 12;
    localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [LEN_W-1:0]   width;
        logic [LEN_W-1:0]   height;
        logic [CLASS_W-1:0] cls;
    } kept_entry_t;

    typedef struct packed {
        logic busy;
        logic hit_v;
        logic hit;
    } iou_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } nms_state_t;

endpackage
`default_nettype wire

@@ sv/per_class_box_suppression_top.sv @@
// Per-class greedy box suppression: top level with sequencer and result register.
//
// Input channel (in_valid / in_stall): one box per transaction, boxes of a frame
// in falling confidence order; first_of_frame empties the kept list and restarts
// numbering before that box. Output channel (out_valid / out_stall): one result
// per box with its number, keep flag and store_overflow flag.
// Configuration channel (cfg_valid / cfg_ready / iou_threshold): always ready;
// write it only while no box is in flight.
// Flow: after acceptance the box walks the kept-box store, reading one entry per
// cycle through its single read port; each entry then passes the five-stage
// overlap pipeline, and the drain and done steps hand the result to the output
// register. With nothing to compare (empty list or first_of_frame) the walk is
// skipped. One box is in work at a time; the next is accepted the cycle after
// the result is loaded into the output register, even while that result waits
// under out_stall.
// A finished box waits in its last step while the output register is occupied.
// Reset clears the kept count, numbering and the threshold (to 29491); store
// contents are not cleared, as only entries written in the current frame are read.
`default_nettype none
module per_class_box_suppression_top #(
    parameter int MAX_KEPT  = 256,
    parameter int MAX_BOXES = 4096
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire                                first_of_frame,
    input  wire  [pcbs_pkg::COORD_W-1:0]       box_left,
    input  wire  [pcbs_pkg::COORD_W-1:0]       box_top,
    input  wire  [pcbs_pkg::LEN_W-1:0]         box_width,
    input  wire  [pcbs_pkg::LEN_W-1:0]         box_height,
    input  wire  [pcbs_pkg::CLASS_W-1:0]       class_id,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic [pcbs_pkg::BOX_NUM_W-1:0]     box_number,
    output logic                               keep,
    output logic                               store_overflow,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [pcbs_pkg::THR_W-1:0]         iou_threshold
);
    import pcbs_pkg::*;

    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int NW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_KEPT);
    localparam logic [NW:0]   NUM_LIMIT  = (NW+1)'(MAX_BOXES);

    nms_state_t state_reg, state_next;
    logic [THR_W-1:0]     thr_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [NW-1:0]        number_reg, number_next;
    logic                 drop_reg, drop_next;
    kept_entry_t          cur_reg, cur_next;
    logic [AREA_W-1:0]    area_reg, area_next;
    logic [BOX_NUM_W-1:0] cur_num_reg, cur_num_next;
    logic                 out_valid_reg, out_valid_next;
    logic [BOX_NUM_W-1:0] out_num_reg, out_num_next;
    logic                 out_keep_reg, out_keep_next;
    logic                 out_ovf_reg, out_ovf_next;

    logic                 issue_v;
    logic                 wr_en;
    logic [NW-1:0]        base_num;
    logic [NW:0]          base_inc;
    logic [CW-1:0]        idx_inc;
    logic                 box_kept;
    kept_entry_t          kept_rd;
    iou_stat_t            iou_stat;

    pcbs_store #(
        .DEPTH (MAX_KEPT),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (cur_reg),
        .rd_en   (issue_v),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (kept_rd)
    );

    pcbs_iou u_iou (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue_v   (issue_v),
        .cur_box   (cur_reg),
        .cur_area  (area_reg),
        .threshold (thr_reg),
        .kept_box  (kept_rd),
        .stat      (iou_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        number_next    = number_reg;
        drop_next      = drop_reg || (iou_stat.hit_v && iou_stat.hit);
        cur_next       = cur_reg;
        area_next      = area_reg;
        cur_num_next   = cur_num_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_num_next   = out_num_reg;
        out_keep_next  = out_keep_reg;
        out_ovf_next   = out_ovf_reg;
        issue_v        = 1'b0;
        wr_en          = 1'b0;
        in_stall       = (state_reg != ST_IDLE);
        base_num       = first_of_frame ? '0 : number_reg;
        base_inc       = {1'b0, base_num} + 1'b1;
        idx_inc        = idx_reg + 1'b1;
        box_kept       = !drop_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cur_next.left   = box_left;
                    cur_next.top    = box_top;
                    cur_next.width  = box_width;
                    cur_next.height = box_height;
                    cur_next.cls    = class_id;
                    area_next       = AREA_W'(box_width * box_height);
                    cur_num_next    = BOX_NUM_W'(base_num);
                    number_next     = (base_inc >= NUM_LIMIT) ? '0 : base_inc[NW-1:0];
                    idx_next        = '0;
                    drop_next       = 1'b0;
                    if (first_of_frame)
                    begin
                        count_next = '0;
                    end
                    state_next = (first_of_frame || count_reg == '0) ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                issue_v  = 1'b1;
                idx_next = idx_inc;
                if (idx_inc == count_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // wait for every in-flight comparison to report
                if (!iou_stat.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_num_next   = cur_num_reg;
                    out_keep_next  = box_kept;
                    out_ovf_next   = box_kept && (count_reg == FULL_COUNT);
                    if (box_kept && count_reg != FULL_COUNT)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= THR_RESET;
            count_reg     <= '0;
            idx_reg       <= '0;
            number_reg    <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            number_reg    <= number_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                thr_reg <= iou_threshold;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        area_reg    <= area_next;
        cur_num_reg <= cur_num_next;
        out_num_reg <= out_num_next;
        out_keep_reg <= out_keep_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign box_number     = out_num_reg;
    assign keep           = out_keep_reg;
    assign store_overflow = out_ovf_reg;

endmodule
`default_nettype wire

@@ sv/pcbs_store.sv @@
// Kept-box store: single write port, single registered read port.
`default_nettype none
module pcbs_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire                        clk,
    input  wire                        wr_en,
    input  wire  [AW-1:0]              wr_addr,
    input  pcbs_pkg::kept_entry_t      wr_data,
    input  wire                        rd_en,
    input  wire  [AW-1:0]              rd_addr,
    output pcbs_pkg::kept_entry_t      rd_data
);
    import pcbs_pkg::*;

    kept_entry_t mem [DEPTH];
    kept_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ sv/pcbs_iou.sv @@
// Pipelined overlap-ratio test of the current box against one kept box per cycle.
`default_nettype none
module pcbs_iou (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              issue_v,
    input  pcbs_pkg::kept_entry_t            cur_box,
    input  wire  [pcbs_pkg::AREA_W-1:0]      cur_area,
    input  wire  [pcbs_pkg::THR_W-1:0]       threshold,
    input  pcbs_pkg::kept_entry_t            kept_box,
    output pcbs_pkg::iou_stat_t              stat
);
    import pcbs_pkg::*;

    logic                v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, hit_v_reg;
    logic                m1_reg, m2_reg, m3_reg, m4_reg, hit_reg;
    logic [LEN_W-1:0]    ow_reg, oh_reg, wk_reg, hk_reg;
    logic [AREA_W-1:0]   inter2_reg, area_b2_reg, inter3_reg, inter4_reg;
    logic [UNION_W-1:0]  uni3_reg;
    logic                nz4_reg;
    logic [PROD_W-1:0]   prod4_reg;

    logic [LEN_W-1:0]    ow_next, oh_next;
    logic [UNION_W-1:0]  uni_next;
    logic [PROD_W-1:0]   scaled_inter;

    function automatic logic [LEN_W-1:0] overlap(
        input logic [COORD_W-1:0] a0,
        input logic [LEN_W-1:0]   alen,
        input logic [COORD_W-1:0] b0,
        input logic [LEN_W-1:0]   blen
    );
        logic signed [EDGE_W-1:0] as, ae, bs, be, lo, hi, diff;
        as = EDGE_W'($signed(a0));
        bs = EDGE_W'($signed(b0));
        ae = as + $signed({2'b00, alen});
        be = bs + $signed({2'b00, blen});
        lo = (as > bs) ? as : bs;
        hi = (ae < be) ? ae : be;
        diff = hi - lo;
        return (hi > lo) ? diff[LEN_W-1:0] : '0;
    endfunction

    always_comb
    begin
        ow_next  = overlap(cur_box.left, cur_box.width, kept_box.left, kept_box.width);
        oh_next  = overlap(cur_box.top, cur_box.height, kept_box.top, kept_box.height);
        uni_next = {1'b0, cur_area} + {1'b0, area_b2_reg} - {1'b0, inter2_reg};
        scaled_inter = {1'b0, inter4_reg, 16'd0};
    end

    // valid chain, aligned with the store's read latency
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            hit_v_reg <= 1'b0;
        end
        else
        begin
            v0_reg    <= issue_v;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            hit_v_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ow_reg      <= ow_next;
        oh_reg      <= oh_next;
        wk_reg      <= kept_box.width;
        hk_reg      <= kept_box.height;
        m1_reg      <= (kept_box.cls == cur_box.cls);
        inter2_reg  <= AREA_W'(ow_reg * oh_reg);
        area_b2_reg <= AREA_W'(wk_reg * hk_reg);
        m2_reg      <= m1_reg;
        uni3_reg    <= uni_next;
        inter3_reg  <= inter2_reg;
        m3_reg      <= m2_reg;
        prod4_reg   <= PROD_W'(threshold * uni3_reg);
        inter4_reg  <= inter3_reg;
        nz4_reg     <= (uni3_reg != '0);
        m4_reg      <= m3_reg;
        hit_reg     <= m4_reg && nz4_reg && (scaled_inter > prod4_reg);
    end

    assign stat.busy  = v0_reg | v1_reg | v2_reg | v3_reg | v4_reg | hit_v_reg;
    assign stat.hit_v = hit_v_reg;
    assign stat.hit   = hit_reg;

endmodule
`default_nettype wire

@@ sv/pcbs_checker.sv @@
// Port-level checks for the per-class box suppression block, bound to the top level.
`default_nettype none
module pcbs_checker (
    input wire                                clk,
    input wire                                rst_n,
    input wire                                in_valid,
    input wire                                in_stall,
    input wire                                out_valid,
    input wire                                out_stall,
    input wire  [pcbs_pkg::BOX_NUM_W-1:0]     box_number,
    input wire                                keep,
    input wire                                store_overflow
);
    import pcbs_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(box_number) &&
        $stable(keep) && $stable(store_overflow))
        else $error("stalled result changed");

    // overflow only ever comes with a kept box
    a_ovf_keep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (keep || !store_overflow))
        else $error("overflow on dropped box");

    // one box in work at a time
    a_one_box: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second box taken while busy");

    // a box cannot finish in the cycle after it is taken
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && out_valid && !out_stall |=> !out_valid)
        else $error("result appeared too early");

endmodule

bind per_class_box_suppression_top pcbs_checker u_pcbs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .box_number     (box_number),
    .keep           (keep),
    .store_overflow (store_overflow)
);
`default_nettype wire
